>>> rtl/pmt_pkg.sv
// pmt_pkg: shared types and constants for the PS/2 mouse packet tracker.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps

package pmt_pkg;

    // Configuration register file
    localparam int REG_W = 13;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_STAGE_WIDTH = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_STAGE_HEIGHT = 1'b1;
    localparam logic [REG_W-1:0] STAGE_WIDTH_RST = 13'd640;
    localparam logic [REG_W-1:0] STAGE_HEIGHT_RST = 13'd480;

    // Position width default
    localparam int POS_BITS_DEF = 13;

    // Byte and delta widths
    localparam int BYTE_W = 8;
    localparam int DX_W = 9;
    localparam int DY_W = 10;

    // Header bit positions
    localparam int HDR_LEFT_BIT = 0;
    localparam int HDR_SYNC_BIT = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_X      = 2'd1,
        PH_Y      = 2'd2
    } phase_t;

    // One registered byte request waiting for the decoder
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } pmt_item_t;

endpackage

>>> rtl/pmt_input_stage.sv
// pmt_input_stage: input register for raw mouse bytes.
// Depends on pmt_pkg.
`timescale 1ns / 1ps

module pmt_input_stage
    import pmt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              out_free,
    output pmt_item_t         item
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;

    // Held byte can only leave when the result register has room
    assign in_stall = valid_reg && !out_free;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            data_reg <= rx_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data = data_reg;

endmodule

>>> rtl/pmt_clamp.sv
// pmt_clamp: adds a signed delta to a position and clamps to 0..bound.
// Depends on pmt_pkg.
`timescale 1ns / 1ps

module pmt_clamp
    import pmt_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic [POS_BITS-1:0]   acc,
    input  logic signed [DY_W-1:0] delta,
    input  logic [REG_W-1:0]      bound_reg,
    output logic [POS_BITS-1:0]   pos
);

    localparam int SW = ((POS_BITS > REG_W) ? POS_BITS : REG_W) + 2;
    localparam logic [SW-1:0] POS_MAX = SW'((64'd1 << POS_BITS) - 64'd1);

    logic signed [SW-1:0] sum;
    logic [SW-1:0]        bound_ext;
    logic [SW-1:0]        bound;

    assign sum = $signed({{(SW-POS_BITS){1'b0}}, acc}) + SW'(delta);
    assign bound_ext = {{(SW-REG_W){1'b0}}, bound_reg};
    assign bound = (bound_ext > POS_MAX) ? POS_MAX : bound_ext;

    always_comb
    begin
        if (sum < 0)
        begin
            pos = '0;
        end
        else if ($unsigned(sum) > bound)
        begin
            pos = bound[POS_BITS-1:0];
        end
        else
        begin
            pos = sum[POS_BITS-1:0];
        end
    end

endmodule

>>> rtl/pmt_decode.sv
// pmt_decode: packet framing state machine, position accumulators and
// result register. Depends on pmt_pkg and pmt_clamp.
`timescale 1ns / 1ps

module pmt_decode
    import pmt_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pmt_item_t              item,
    input  logic                   out_free,
    input  logic [REG_W-1:0]       stage_width,
    input  logic [REG_W-1:0]       stage_height,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [POS_BITS-1:0]    pos_x,
    output logic [POS_BITS-1:0]    pos_y,
    output logic signed [DX_W-1:0] delta_x,
    output logic signed [DY_W-1:0] delta_y,
    output logic                   left_button,
    output logic                   button_changed
);

    phase_t phase_reg, phase_next;

    logic [BYTE_W-1:0]   header_reg;
    logic [BYTE_W-1:0]   x_byte_reg;
    logic [POS_BITS-1:0] acc_x_reg, acc_x_next;
    logic [POS_BITS-1:0] acc_y_reg, acc_y_next;
    logic                last_button_reg;
    logic                out_valid_reg, out_valid_next;

    logic                   fire;
    logic                   take_header;
    logic                   take_x;
    logic                   packet_done;
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy_raw;
    logic signed [DY_W-1:0] dy;
    logic                   btn;

    assign fire = item.valid && out_free;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            unique case (phase_reg)
                PH_X:
                begin
                    phase_next = PH_Y;
                end
                PH_Y:
                begin
                    phase_next = PH_HEADER;
                end
                default:
                begin
                    phase_next = item.data[HDR_SYNC_BIT] ? PH_X : PH_HEADER;
                end
            endcase
        end
    end

    // Phase outputs
    always_comb
    begin
        take_header = 1'b0;
        take_x = 1'b0;
        packet_done = 1'b0;
        unique case (phase_reg)
            PH_X:
            begin
                take_x = fire;
            end
            PH_Y:
            begin
                packet_done = fire;
            end
            default:
            begin
                take_header = fire && item.data[HDR_SYNC_BIT];
            end
        endcase
    end

    // Sign extension from header bits, Y negated
    assign dx = $signed({header_reg[HDR_XSIGN_BIT], x_byte_reg});
    assign dy_raw = $signed({header_reg[HDR_YSIGN_BIT], item.data});
    assign dy = -DY_W'(dy_raw);
    assign btn = header_reg[HDR_LEFT_BIT];

    pmt_clamp #(
        .POS_BITS (POS_BITS)
    ) u_clamp_x (
        .acc       (acc_x_reg),
        .delta     (DY_W'(dx)),
        .bound_reg (stage_width),
        .pos       (acc_x_next)
    );

    pmt_clamp #(
        .POS_BITS (POS_BITS)
    ) u_clamp_y (
        .acc       (acc_y_reg),
        .delta     (dy),
        .bound_reg (stage_height),
        .pos       (acc_y_next)
    );

    assign out_valid_next = packet_done ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            header_reg <= '0;
            x_byte_reg <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            last_button_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            out_valid_reg <= out_valid_next;
            if (take_header)
            begin
                header_reg <= item.data;
            end
            if (take_x)
            begin
                x_byte_reg <= item.data;
            end
            if (packet_done)
            begin
                acc_x_reg <= acc_x_next;
                acc_y_reg <= acc_y_next;
                last_button_reg <= btn;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (packet_done)
        begin
            pos_x <= acc_x_next;
            pos_y <= acc_y_next;
            delta_x <= dx;
            delta_y <= dy;
            left_button <= btn;
            button_changed <= btn ^ last_button_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/ps2_mouse_packet_tracker.sv
// ps2_mouse_packet_tracker: 3-byte PS/2 mouse packet decoder with clamped position.
// Registers: input reg, then result reg, with the single-pass decode between them.
// Throughput: one byte per cycle while the result reg has room, set by the one-pass decode.
// Reset (rst_n low, async): awaiting header, position 0,0, button released,
// stage_width 640, stage_height 480, no request held on either side.
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker
    import pmt_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Configuration write port
    input  logic                   cfg_we,
    input  logic [REG_IDX_W-1:0]   cfg_index,
    input  logic [REG_W-1:0]       cfg_wdata,

    // Byte request channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [BYTE_W-1:0]      rx_byte,

    // Result request channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [POS_BITS-1:0]    pos_x,
    output logic [POS_BITS-1:0]    pos_y,
    output logic signed [DX_W-1:0] delta_x,
    output logic signed [DY_W-1:0] delta_y,
    output logic                   left_button,
    output logic                   button_changed
);

    logic [REG_W-1:0] stage_width_reg;
    logic [REG_W-1:0] stage_height_reg;

    pmt_item_t item;
    logic      out_free;

    // Clamp bounds. Values above the position range saturate inside
    // the clamp units; a zero bound pins the coordinate at 0.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_width_reg <= STAGE_WIDTH_RST;
            stage_height_reg <= STAGE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STAGE_WIDTH:
                begin
                    stage_width_reg <= cfg_wdata;
                end
                REG_STAGE_HEIGHT:
                begin
                    stage_height_reg <= cfg_wdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result register has room when it is empty or being drained this cycle.
    // The input register then moves its byte into the decoder, so a new byte
    // request is taken every cycle while the result side keeps up.
    assign out_free = !out_valid || !out_stall;

    pmt_input_stage u_input (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .out_free (out_free),
        .item     (item)
    );

    // Framing: bytes without the sync bit are dropped while hunting for a
    // header; the X and Y bytes are taken whatever their bit 3. The third
    // byte completes the packet, updates the position and loads a result.
    pmt_decode #(
        .POS_BITS (POS_BITS)
    ) u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .out_free       (out_free),
        .stage_width    (stage_width_reg),
        .stage_height   (stage_height_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .delta_x        (delta_x),
        .delta_y        (delta_y),
        .left_button    (left_button),
        .button_changed (button_changed)
    );

endmodule

>>> dv/ps2_mouse_packet_checker.sv
// ps2_mouse_packet_checker: watches the byte, result and config ports of the
// PS/2 mouse packet tracker, predicts each packet result and compares it.
// Depends on rtl/pmt_pkg.sv for widths, register indexes and phase_t.
`timescale 1ns / 1ps

module ps2_mouse_packet_checker
    import pmt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [REG_IDX_W-1:0]   cfg_index,
    input  logic [REG_W-1:0]       cfg_wdata,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [BYTE_W-1:0]      rx_byte,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [POS_BITS_DEF-1:0] pos_x,
    input  logic [POS_BITS_DEF-1:0] pos_y,
    input  logic signed [DX_W-1:0] delta_x,
    input  logic signed [DY_W-1:0] delta_y,
    input  logic                   left_button,
    input  logic                   button_changed,
    output int                     fail_count,
    output int                     pending
);

    localparam int POS_BITS = POS_BITS_DEF;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam int SIGN_WEIGHT = 1 << BYTE_W;
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [POS_BITS-1:0] pos_x;
        logic [POS_BITS-1:0] pos_y;
        logic [DX_W-1:0]     delta_x;
        logic [DY_W-1:0]     delta_y;
        logic                left;
        logic                changed;
    } mouse_move_t;

    mouse_move_t       expected_moves[$];

    // shadow config and decoder state
    logic [REG_W-1:0]    width_reg;
    logic [REG_W-1:0]    height_reg;
    phase_t              phase;
    logic [BYTE_W-1:0]   header_q;
    logic [BYTE_W-1:0]   x_q;
    logic [POS_BITS-1:0] acc_x;
    logic [POS_BITS-1:0] acc_y;
    logic                last_left;

    initial fail_count = 0;

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
            $display("%0t ps2 checker: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // bound saturates at the position width; negative sums pin at 0
    function automatic logic [POS_BITS-1:0] clamp_axis(input logic [POS_BITS-1:0] acc,
                                                        input int delta,
                                                        input logic [REG_W-1:0] bound_reg);
        int bound;
        int total;
        bound = (bound_reg > POS_MAX) ? int'(POS_MAX) : int'(bound_reg);
        total = int'(acc) + delta;
        if (total < 0)
            total = 0;
        if (total > bound)
            total = bound;
        return total[POS_BITS-1:0];
    endfunction

    task automatic decode_mouse_byte(input logic [BYTE_W-1:0] b);
        int          dx;
        int          dy;
        mouse_move_t m;
        case (phase)
            PH_X:
            begin
                x_q   = b;
                phase = PH_Y;
            end
            PH_Y:
            begin
                phase = PH_HEADER;
                dx = int'(x_q);
                dy = int'(b);
                if (header_q[HDR_XSIGN_BIT])
                    dx -= SIGN_WEIGHT;
                if (header_q[HDR_YSIGN_BIT])
                    dy -= SIGN_WEIGHT;
                dy = -dy;
                acc_x = clamp_axis(acc_x, dx, width_reg);
                acc_y = clamp_axis(acc_y, dy, height_reg);
                m.pos_x   = acc_x;
                m.pos_y   = acc_y;
                m.delta_x = dx[DX_W-1:0];
                m.delta_y = dy[DY_W-1:0];
                m.left    = header_q[HDR_LEFT_BIT];
                m.changed = (m.left != last_left);
                last_left = m.left;
                expected_moves.insert(expected_moves.size(), m);
            end
            default:
            begin
                // resync: only a byte with the sync bit starts a packet
                if (b[HDR_SYNC_BIT])
                begin
                    header_q = b;
                    phase    = PH_X;
                end
                else
                begin
                    phase = PH_HEADER;
                end
            end
        endcase
    endtask

    task automatic check_result();
        mouse_move_t want;
        if (expected_moves.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result pos=(%0d,%0d)", pos_x, pos_y));
            return;
        end
        want = expected_moves.pop_front();
        compare_field("pos_x", 16'(pos_x), 16'(want.pos_x));
        compare_field("pos_y", 16'(pos_y), 16'(want.pos_y));
        compare_field("delta_x", 16'($unsigned(delta_x)), 16'(want.delta_x));
        compare_field("delta_y", 16'($unsigned(delta_y)), 16'(want.delta_y));
        compare_field("left_button", 16'(left_button), 16'(want.left));
        compare_field("button_changed", 16'(button_changed), 16'(want.changed));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = STAGE_WIDTH_RST;
            height_reg = STAGE_HEIGHT_RST;
            phase      = PH_HEADER;
            header_q   = '0;
            x_q        = '0;
            acc_x      = '0;
            acc_y      = '0;
            last_left  = 1'b0;
            expected_moves.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                decode_mouse_byte(rx_byte);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STAGE_WIDTH:  width_reg  = cfg_wdata;
                    REG_STAGE_HEIGHT: height_reg = cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending = expected_moves.size();
    end

endmodule

>>> dv/tb_ps2_mouse_packet_tracker.sv
// tb_ps2_mouse_packet_tracker: stimulus and verdict for the PS/2 mouse packet tracker.
// Depends on rtl/pmt_pkg.sv, rtl/ps2_mouse_packet_tracker.sv and
// dv/ps2_mouse_packet_checker.sv, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_tracker;
    import pmt_pkg::*;

    // hard limit on simulated time, in ns
    localparam longint RUN_LIMIT_NS = 64'd4_000_000;
    // idle margin after the last result before config writes
    localparam int DRAIN_CYCLES = 6;
    localparam int ITEMS_PER_SETTING = 330;
    localparam int NUM_SETTINGS = 6;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [REG_IDX_W-1:0]   cfg_index;
    logic [REG_W-1:0]       cfg_wdata;
    logic                   in_valid;
    logic                   in_stall;
    logic [BYTE_W-1:0]      rx_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic [POS_BITS_DEF-1:0] pos_x;
    logic [POS_BITS_DEF-1:0] pos_y;
    logic signed [DX_W-1:0] delta_x;
    logic signed [DY_W-1:0] delta_y;
    logic                   left_button;
    logic                   button_changed;

    int                     fail_count;
    int                     pending;

    // idle percentages for the sender and the result receiver
    int unsigned            snd_idle_pct;
    int unsigned            rcv_idle_pct;
    // long receiver hold-off: stimulus bumps hold_starts, the receiver
    // process notices the change and counts hold_left down itself
    int                     hold_starts = 0;
    int                     hold_seen = 0;
    int                     hold_left = 0;

    ps2_mouse_packet_tracker DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .delta_x        (delta_x),
        .delta_y        (delta_y),
        .left_button    (left_button),
        .button_changed (button_changed)
    );

    ps2_mouse_packet_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .delta_x        (delta_x),
        .delta_y        (delta_y),
        .left_button    (left_button),
        .button_changed (button_changed),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // 4 ns clock: 2 ns high, 2 ns low
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result receiver: stall changes only on the falling edge. A pending
    // hold-off keeps stall high for its full count, which backs the tracker
    // up until it stalls the byte channel.
    always @(negedge clk)
    begin
        if (hold_seen != hold_starts)
        begin
            hold_seen = hold_starts;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (!rst_n)
            out_stall = 1'b0;
        else if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
            out_stall = ($urandom_range(99) < rcv_idle_pct);
    end

    // Hard stop in case the tracker hangs or drops a result.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb_ps2_mouse_packet_tracker failed");
        $finish;
    end

    // Offer one byte request, after a random number of idle cycles, and hold
    // it until accepted. Returns at the falling edge after acceptance with
    // valid still high, so back-to-back requests need no extra edge.
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid = 1'b0;
            rx_byte  = BYTE_W'($urandom_range(255));
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Config writes only while the tracker is idle: every predicted result
    // has come out and the last header/X byte has had time to settle.
    task automatic write_stage(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = REG_STAGE_WIDTH;
        cfg_wdata = w;
        @(negedge clk);
        cfg_index = REG_STAGE_HEIGHT;
        cfg_wdata = h;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Mostly well-formed packets with random content. Header sign bits lean
    // toward a drift direction half the time so positions reach the clamps.
    // About one request in ten is a stray byte: dropped if the sync bit is
    // clear, else it starts a misaligned packet that the stream resyncs from.
    // Only packet bytes count toward n.
    task automatic random_traffic(input int unsigned n);
        int unsigned       sent;
        logic [BYTE_W-1:0] hdr;
        bit                drift_x;
        bit                drift_y;
        sent    = 0;
        drift_x = 1'($urandom_range(1));
        drift_y = 1'($urandom_range(1));
        while (sent < n)
        begin
            if ($urandom_range(9) == 0)
                push_byte(BYTE_W'($urandom_range(255)));
            else
            begin
                hdr = BYTE_W'($urandom_range(255));
                hdr[HDR_SYNC_BIT] = 1'b1;
                if ($urandom_range(1))
                    hdr[HDR_XSIGN_BIT] = drift_x;
                if ($urandom_range(1))
                    hdr[HDR_YSIGN_BIT] = drift_y;
                push_byte(hdr);
                push_byte(BYTE_W'($urandom_range(255)));
                push_byte(BYTE_W'($urandom_range(255)));
                sent += 3;
            end
            if ($urandom_range(63) == 0)
                drift_x = !drift_x;
            if ($urandom_range(63) == 0)
                drift_y = !drift_y;
        end
    endtask

    initial
    begin : stimulus
        logic [BYTE_W-1:0] directed_bytes[$];
        logic [REG_W-1:0]  width_set[NUM_SETTINGS];
        logic [REG_W-1:0]  height_set[NUM_SETTINGS];
        int                s;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_STAGE_WIDTH;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        rx_byte      = '0;
        snd_idle_pct = 23;
        rcv_idle_pct = 87;

        // Settings: zero bounds pin both axes; 1 / 4096 and 4096 / 1 are the
        // nominal extremes; all-ones is the widest register value; then a
        // small bound right after the widest one, so positions sit above
        // it until the next packet clamps them; last a random pair.
        width_set  = '{13'd0, 13'd1, 13'd4096, 13'd8191, 13'd17, 13'd640};
        height_set = '{13'd0, 13'd4096, 13'd1, 13'd8191, 13'd9, 13'd480};
        width_set[NUM_SETTINGS-1]  = REG_W'($urandom_range(4096, 1));
        height_set[NUM_SETTINGS-1] = REG_W'($urandom_range(4096, 1));

        // Directed requests at the reset bounds (640 x 480):
        //   two stray bytes with the sync bit clear (all zero, all others set)
        //   largest positive X, zero Y, left pressed
        //   most negative X, Y sign gives the largest downward move, released
        //   overflow bits set with both signs, left pressed again
        //   data bytes with the sync bit clear are still taken as data
        //   Y sign with 1 gives a raw -255, a downward move of 255
        //   positive X with the largest upward move, then a zero move
        directed_bytes = '{8'h00, 8'hF7,
                           8'h09, 8'hFF, 8'h00,
                           8'h38, 8'h00, 8'h00,
                           8'hF9, 8'h80, 8'hFF,
                           8'h0F, 8'h00, 8'h07,
                           8'h28, 8'h01, 8'h01,
                           8'h08, 8'h7F, 8'hFF,
                           8'h08, 8'h00, 8'h00};

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_bytes[i])
            push_byte(directed_bytes[i]);

        for (s = 0; s < NUM_SETTINGS; s++)
        begin
            write_stage(width_set[s], height_set[s]);
            // idling: sender light / receiver heavy, then swapped, then none
            if (s < 2)
            begin
                snd_idle_pct = 23;
                rcv_idle_pct = 87;
            end
            else if (s < 4)
            begin
                snd_idle_pct = 87;
                rcv_idle_pct = 23;
            end
            else
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            // with the sender at full rate, hold results back long enough
            // for the tracker to fill and push back on the byte channel
            if (s == 4)
                hold_starts++;
            random_traffic(ITEMS_PER_SETTING);
        end

        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_ps2_mouse_packet_tracker passed");
        else
            $display("tb_ps2_mouse_packet_tracker failed");
        $finish;
    end

endmodule

>>> ps2_mouse_packet_tracker.f
rtl/pmt_pkg.sv
rtl/pmt_input_stage.sv
rtl/pmt_clamp.sv
rtl/pmt_decode.sv
rtl/ps2_mouse_packet_tracker.sv
dv/ps2_mouse_packet_checker.sv
dv/tb_ps2_mouse_packet_tracker.sv
